// ===== hw/rtl/a2q_pkg.sv =====
// ----------------------------------------------------------------------------
// a2q_pkg
// Shared types, codes and constants for the decimal text to Q7.8 converter.
// ----------------------------------------------------------------------------
`default_nettype none

package a2q_pkg;

  // Default number of fraction digits kept (range 1..7)
  localparam int MaxFracDigitsDef = 6;

  // Fixed widths
  localparam int IntW     = 8;   // integer accumulator
  localparam int FracDigW = 3;   // fraction digit count
  localparam int QuoW     = 9;   // rounded fraction quotient, at most 256
  localparam int MagW     = 17;  // int*256 + quotient
  localparam int CharW    = 8;
  localparam int ValueW   = 16;

  localparam logic [CharW-1:0] ChZero  = 8'h30;
  localparam logic [CharW-1:0] ChNine  = 8'h39;
  localparam logic [CharW-1:0] ChMinus = 8'h2D;
  localparam logic [CharW-1:0] ChPlus  = 8'h2B;
  localparam logic [CharW-1:0] ChPoint = 8'h2E;

  localparam logic [MagW-1:0] LimitPos = 17'd32767;
  localparam logic [MagW-1:0] LimitNeg = 17'd32768;

  typedef enum logic [2:0] {
    PH_START,
    PH_SIGNED,
    PH_INT,
    PH_POINT,
    PH_FRAC,
    PH_DONE
  } a2q_phase_e;

  typedef enum logic [1:0] {
    STAT_OK     = 2'd0,
    STAT_FORMAT = 2'd1,
    STAT_RANGE  = 2'd2
  } a2q_status_e;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_LOAD,
    ST_DIV,
    ST_FIN
  } a2q_state_e;

  // Summary of the parsed number, parser to top
  typedef struct packed {
    logic                fmt_bad;
    logic                negative;
    logic                int_ovf;
    logic [FracDigW-1:0] frac_digits;
  } a2q_parse_t;

  function automatic logic [23:0] pow10(input logic [FracDigW-1:0] n);
    logic [23:0] p;
    case (n)
      3'd0:    p = 24'd1;
      3'd1:    p = 24'd10;
      3'd2:    p = 24'd100;
      3'd3:    p = 24'd1000;
      3'd4:    p = 24'd10000;
      3'd5:    p = 24'd100000;
      3'd6:    p = 24'd1000000;
      3'd7:    p = 24'd10000000;
      default: p = 24'd1;
    endcase
    return p;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/a2q_parse.sv =====
// ----------------------------------------------------------------------------
// a2q_parse
// Character parser: sign, integer and fraction accumulators, parse phase.
// ----------------------------------------------------------------------------
`default_nettype none

module a2q_parse import a2q_pkg::*; #(
  parameter int MaxFracDigits = MaxFracDigitsDef,
  parameter int FracW         = 20
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              take_i,     // character transfer this cycle
  input  wire logic [CharW-1:0]  char_code_i,
  input  wire logic              clear_i,    // result done, back to start
  output a2q_parse_t             info_o,
  output logic [IntW-1:0]        int_acc_o,
  output logic [FracW-1:0]       frac_acc_o
);

  a2q_phase_e          phase_q, phase_d;
  logic                neg_q, neg_d;
  logic [IntW-1:0]     int_q, int_d;
  logic                ovf_q, ovf_d;
  logic [FracW-1:0]    frac_q, frac_d;
  logic [FracDigW-1:0] fdig_q, fdig_d;
  logic                ferr_q, ferr_d;

  logic                is_dig;
  logic [3:0]          dig;
  logic [IntW+3:0]     int_next;
  logic [FracW+3:0]    frac_next;
  logic                int_add, frac_add;

  assign is_dig    = (char_code_i >= ChZero) && (char_code_i <= ChNine);
  assign dig       = is_dig ? 4'(char_code_i - ChZero) : 4'd0;
  // x*10 + d as shifts and adds
  assign int_next  = ({4'd0, int_q} << 3) + ({4'd0, int_q} << 1) + (IntW+4)'(dig);
  assign frac_next = ({4'd0, frac_q} << 3) + ({4'd0, frac_q} << 1) + (FracW+4)'(dig);

  always_comb begin
    phase_d  = phase_q;
    neg_d    = neg_q;
    ferr_d   = ferr_q;
    int_add  = 1'b0;
    frac_add = 1'b0;
    if (take_i) begin
      case (phase_q)
        PH_START: begin
          if (char_code_i == ChMinus) begin
            neg_d   = 1'b1;
            phase_d = PH_SIGNED;
          end else if (char_code_i == ChPlus) begin
            phase_d = PH_SIGNED;
          end else if (is_dig) begin
            int_add = 1'b1;
            phase_d = PH_INT;
          end else begin
            ferr_d  = 1'b1;
            phase_d = PH_DONE;
          end
        end
        PH_SIGNED: begin
          if (is_dig) begin
            int_add = 1'b1;
            phase_d = PH_INT;
          end else begin
            ferr_d  = 1'b1;
            phase_d = PH_DONE;
          end
        end
        PH_INT: begin
          if (is_dig) begin
            int_add = 1'b1;
          end else if (char_code_i == ChPoint) begin
            phase_d = PH_POINT;
          end else begin
            phase_d = PH_DONE;
          end
        end
        PH_POINT: begin
          if (is_dig) begin
            frac_add = 1'b1;
            phase_d  = PH_FRAC;
          end else begin
            ferr_d  = 1'b1;
            phase_d = PH_DONE;
          end
        end
        PH_FRAC: begin
          if (is_dig) begin
            frac_add = 1'b1;
          end else begin
            phase_d = PH_DONE;
          end
        end
        default: ;
      endcase
    end

    int_d = int_q;
    ovf_d = ovf_q;
    if (int_add) begin
      // saturate above 255
      if (int_next > (IntW+4)'({IntW{1'b1}})) begin
        ovf_d = 1'b1;
        int_d = {IntW{1'b1}};
      end else begin
        int_d = int_next[IntW-1:0];
      end
    end

    frac_d = frac_q;
    fdig_d = fdig_q;
    // extra fraction digits are dropped
    if (frac_add && (fdig_q < FracDigW'(MaxFracDigits))) begin
      frac_d = frac_next[FracW-1:0];
      fdig_d = fdig_q + 1'b1;
    end

    if (clear_i) begin
      phase_d = PH_START;
      neg_d   = 1'b0;
      int_d   = '0;
      ovf_d   = 1'b0;
      frac_d  = '0;
      fdig_d  = '0;
      ferr_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_START;
      neg_q   <= 1'b0;
      int_q   <= '0;
      ovf_q   <= 1'b0;
      frac_q  <= '0;
      fdig_q  <= '0;
      ferr_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      neg_q   <= neg_d;
      int_q   <= int_d;
      ovf_q   <= ovf_d;
      frac_q  <= frac_d;
      fdig_q  <= fdig_d;
      ferr_q  <= ferr_d;
    end
  end

  // text that stops before a digit, or right after the point, is malformed
  assign info_o.fmt_bad     = ferr_q || (phase_q == PH_START) ||
                              (phase_q == PH_SIGNED) || (phase_q == PH_POINT);
  assign info_o.negative    = neg_q;
  assign info_o.int_ovf     = ovf_q;
  assign info_o.frac_digits = fdig_q;
  assign int_acc_o          = int_q;
  assign frac_acc_o         = frac_q;

endmodule

`default_nettype wire

// ===== hw/rtl/a2q_div.sv =====
// ----------------------------------------------------------------------------
// a2q_div
// Restoring divider, one quotient bit per cycle, for the fraction rounding.
// ----------------------------------------------------------------------------
`default_nettype none

module a2q_div import a2q_pkg::*; #(
  parameter int NumW = 29,
  parameter int DenW = 20
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start_i,
  input  wire logic [NumW-1:0] num_i,
  input  wire logic [DenW-1:0] den_i,
  output logic                 done_o,
  output logic [QuoW-1:0]      quo_o
);

  localparam int CntW = $clog2(QuoW + 1);

  logic [NumW-1:0] rem_q, rem_d;
  logic [NumW-1:0] dsr_q, dsr_d;
  logic [QuoW-1:0] quo_q, quo_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            done_q, done_d;
  logic            ge;

  // quotient is known to be below 2^QuoW, so the divisor starts shifted
  // up by QuoW-1 and walks down one bit per step
  assign ge = rem_q >= dsr_q;

  always_comb begin
    rem_d  = rem_q;
    dsr_d  = dsr_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = num_i;
      dsr_d = NumW'(den_i) << (QuoW - 1);
      quo_d = '0;
      cnt_d = CntW'(QuoW);
    end else if (cnt_q != '0) begin
      rem_d  = ge ? (rem_q - dsr_q) : rem_q;
      dsr_d  = dsr_q >> 1;
      quo_d  = {quo_q[QuoW-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CntW'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    dsr_q <= dsr_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

`default_nettype wire

// ===== hw/rtl/ascii_decimal_to_q7_8_core.sv =====
// A result is valid after the last character passes the load, divide and finish states.
// Throughput: one character per cycle; after the last character the input is
//   stalled through divider start, 9 divide steps plus the done flag, and result write.
// While a result waits for transfer, characters of the next number are still taken;
//   only its result write, and so the input, waits for that transfer.
// Reset (asynchronous, active low) returns the parser to the start phase and drops any pending result.
// ----------------------------------------------------------------------------
// ascii_decimal_to_q7_8_core
// Decimal text to signed Q7.8 converter with status. Reset drops any pending result.
// ----------------------------------------------------------------------------
`default_nettype none

module ascii_decimal_to_q7_8_core import a2q_pkg::*; #(
  parameter int MAX_FRAC_DIGITS = MaxFracDigitsDef
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [CharW-1:0]   char_code_i,
  input  wire logic               last_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic signed [ValueW-1:0] value_o,
  output logic [1:0]              status_o
);

  localparam int FracW = $clog2(int'(pow10(FracDigW'(MAX_FRAC_DIGITS))) + 1);
  localparam int NumW  = FracW + QuoW;

  a2q_state_e       state_q, state_d;
  a2q_parse_t       info;
  logic [IntW-1:0]  int_acc;
  logic [FracW-1:0] frac_acc;
  logic [FracW-1:0] pw;
  logic [NumW-1:0]  num;
  logic [QuoW-1:0]  quo;
  logic             div_done;
  logic             take, clear, div_start, load;

  logic              out_valid_q, out_valid_d;
  logic [ValueW-1:0] value_q, value_d;
  a2q_status_e       status_q, status_d;

  logic [MagW-1:0]   mag;
  logic [MagW-1:0]   limit;

  assign take = in_valid_i && !in_stall_o;

  a2q_parse #(
    .MaxFracDigits (MAX_FRAC_DIGITS),
    .FracW         (FracW)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .char_code_i (char_code_i),
    .clear_i     (clear),
    .info_o      (info),
    .int_acc_o   (int_acc),
    .frac_acc_o  (frac_acc)
  );

  // rounded fraction = (frac*256 + p/2) / p, with p = 10^digits
  assign pw  = FracW'(pow10(info.frac_digits));
  assign num = {1'b0, frac_acc, 8'h00} + NumW'(pw >> 1);

  a2q_div #(
    .NumW (NumW),
    .DenW (FracW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (num),
    .den_i   (pw),
    .done_o  (div_done),
    .quo_o   (quo)
  );

  assign mag   = {1'b0, int_acc, 8'h00} + MagW'(quo);
  assign limit = info.negative ? LimitNeg : LimitPos;

  always_comb begin
    state_d     = state_q;
    in_stall_o  = 1'b1;
    div_start   = 1'b0;
    load        = 1'b0;
    clear       = 1'b0;
    case (state_q)
      ST_RUN: begin
        in_stall_o = 1'b0;
        if (take && last_i) state_d = ST_LOAD;
      end
      ST_LOAD: begin
        div_start = 1'b1;
        state_d   = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) state_d = ST_FIN;
      end
      ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          load    = 1'b1;
          clear   = 1'b1;
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  // result formatting; format errors win over range errors
  always_comb begin
    value_d  = value_q;
    status_d = status_q;
    if (load) begin
      value_d = '0;
      if (info.fmt_bad) begin
        status_d = STAT_FORMAT;
      end else if (info.int_ovf || (mag > limit)) begin
        status_d = STAT_RANGE;
      end else begin
        status_d = STAT_OK;
        value_d  = info.negative ? (ValueW'(0) - mag[ValueW-1:0]) : mag[ValueW-1:0];
      end
    end
    out_valid_d = load || (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q  <= value_d;
    status_q <= status_d;
  end

  assign out_valid_o = out_valid_q;
  assign value_o     = signed'(value_q);
  assign status_o    = status_q;

  // error results carry a zero value
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o != STAT_OK)) |-> (value_o == 16'sd0))
    else $error("nonzero value with error status");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((status_o == STAT_OK) || (status_o == STAT_FORMAT) ||
                     (status_o == STAT_RANGE)))
    else $error("bad status code");

  a_div_in_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (state_q == ST_DIV))
    else $error("divider finished outside divide state");

  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (out_valid_q && (state_q == ST_RUN)))
    else $error("result load did not produce a valid output");

  a_last_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (take && last_i) |=> ##1 (state_q == ST_DIV))
    else $error("last character did not start the divider");

endmodule

`default_nettype wire

// ===== tb/ascii_decimal_to_q7_8_core_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ascii_decimal_to_q7_8_core_tb
// Self-checking bench for the decimal text to Q7.8 converter. A directed set of
// numbers covers range limits, rounding carry and malformed text. Random
// numbers follow, most of them well formed. Both sides idle at random. Each
// conversion result is checked against a parser model that runs alongside.
// ----------------------------------------------------------------------------

module ascii_decimal_to_q7_8_core_tb;
  import a2q_pkg::*;

  localparam int ClkPeriod     = 12;
  localparam int TimeoutCycles = 400000;
  localparam int CharTarget    = 1300;
  localparam int HoldOffCycles = 600;
  localparam int DrainCycles   = 40;

  typedef struct packed {
    logic [CharW-1:0] ch;
    logic             lst;
  } text_char_t;

  typedef struct packed {
    logic signed [ValueW-1:0] value;
    a2q_status_e              status;
  } q78_result_t;

  logic                     clk_i       = 1'b0;
  logic                     rst_ni      = 1'b0;
  logic                     in_valid_i  = 1'b0;
  logic                     in_stall_o;
  logic [CharW-1:0]         char_code_i = '0;
  logic                     last_i      = 1'b0;
  logic                     out_valid_o;
  logic                     out_stall_i = 1'b0;
  logic signed [ValueW-1:0] value_o;
  logic [1:0]               status_o;

  ascii_decimal_to_q7_8_core i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .char_code_i (char_code_i),
    .last_i      (last_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o),
    .status_o    (status_o)
  );

  always begin
    clk_i = 1'b1;
    #(ClkPeriod / 2);
    clk_i = 1'b0;
    #(ClkPeriod / 2);
  end

  text_char_t  text_q[$];
  q78_result_t conv_expected_q[$];
  int          errors     = 0;
  int          chars_sent = 0;
  int          results_in = 0;

  // parser model state
  a2q_phase_e      prs_phase;
  logic            prs_neg;
  logic [IntW-1:0] prs_int;
  logic            prs_int_ovf;
  logic [23:0]     prs_frac;
  logic [2:0]      prs_frac_n;
  logic            prs_fmt_err;

  task automatic note_error(input string msg);
    errors++;
    if (errors <= 10) $display("ERROR @%0t: %s", $realtime, msg);
  endtask

  task automatic clear_parser();
    prs_phase   = PH_START;
    prs_neg     = 1'b0;
    prs_int     = '0;
    prs_int_ovf = 1'b0;
    prs_frac    = '0;
    prs_frac_n  = '0;
    prs_fmt_err = 1'b0;
  endtask

  task automatic take_int_digit(input logic [3:0] d);
    logic [11:0] iv;
    iv = prs_int * 12'd10 + d;
    if (iv > 12'd255) begin
      prs_int_ovf = 1'b1;
      prs_int     = 8'd255;
    end else begin
      prs_int = iv[7:0];
    end
  endtask

  task automatic take_frac_digit(input logic [3:0] d);
    // digits past the kept count are consumed and dropped
    if (prs_frac_n < MaxFracDigitsDef) begin
      prs_frac   = 24'(prs_frac * 24'd10 + 24'(d));
      prs_frac_n = prs_frac_n + 3'd1;
    end
  endtask

  task automatic parse_char(input logic [CharW-1:0] c, input logic lst);
    logic              dig;
    logic [3:0]        d;
    logic [MagW-1:0]   mag;
    longint unsigned   p;
    longint unsigned   q;
    q78_result_t       r;
    dig = (c >= ChZero) && (c <= ChNine);
    d   = dig ? 4'(c - ChZero) : 4'd0;
    case (prs_phase)
      PH_START: begin
        if (c == ChMinus) begin
          prs_neg   = 1'b1;
          prs_phase = PH_SIGNED;
        end else if (c == ChPlus) begin
          prs_phase = PH_SIGNED;
        end else if (dig) begin
          take_int_digit(d);
          prs_phase = PH_INT;
        end else begin
          prs_fmt_err = 1'b1;
          prs_phase   = PH_DONE;
        end
      end
      PH_SIGNED: begin
        if (dig) begin
          take_int_digit(d);
          prs_phase = PH_INT;
        end else begin
          prs_fmt_err = 1'b1;
          prs_phase   = PH_DONE;
        end
      end
      PH_INT: begin
        if (dig) take_int_digit(d);
        else if (c == ChPoint) prs_phase = PH_POINT;
        else prs_phase = PH_DONE;
      end
      PH_POINT: begin
        if (dig) begin
          take_frac_digit(d);
          prs_phase = PH_FRAC;
        end else begin
          prs_fmt_err = 1'b1;
          prs_phase   = PH_DONE;
        end
      end
      PH_FRAC: begin
        if (dig) take_frac_digit(d);
        else prs_phase = PH_DONE;
      end
      default: ;
    endcase

    if (lst) begin
      r.value = '0;
      if (prs_fmt_err || prs_phase == PH_START || prs_phase == PH_SIGNED ||
          prs_phase == PH_POINT) begin
        r.status = STAT_FORMAT;
      end else begin
        mag = MagW'(prs_int) << 8;
        if (prs_frac_n != 0) begin
          p = 1;
          repeat (prs_frac_n) p = p * 10;
          // round half up in magnitude; may carry a full unit into the integer
          q = (prs_frac * 256 + p / 2) / p;
          mag = mag + MagW'(q);
        end
        if (prs_int_ovf || mag > (prs_neg ? LimitNeg : LimitPos)) begin
          r.status = STAT_RANGE;
        end else begin
          r.status = STAT_OK;
          r.value  = prs_neg ? ValueW'(-mag) : ValueW'(mag);
        end
      end
      conv_expected_q.push_back(r);
      clear_parser();
    end
  endtask

  // ---------------- stimulus construction ----------------

  task automatic push_char(input logic [CharW-1:0] c, input logic lst);
    text_char_t t;
    t.ch  = c;
    t.lst = lst;
    text_q.push_back(t);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], i == s.len() - 1);
  endtask

  task automatic push_random_number();
    logic [CharW-1:0] txt[$];
    string            s;
    int               pick;
    int               n;
    logic             nines;
    pick = $urandom_range(0, 99);
    if (pick >= 90) begin
      // noise: raw bytes
      n = $urandom_range(1, 6);
      repeat (n) txt.push_back(CharW'($urandom_range(0, 255)));
    end else begin
      case ($urandom_range(0, 3))
        0:       txt.push_back(ChMinus);
        1:       txt.push_back(ChPlus);
        default: ;
      endcase
      case ($urandom_range(0, 3))
        0, 1:    s = $sformatf("%0d", $urandom_range(0, 127));
        2:       s = $sformatf("%0d", $urandom_range(120, 260));
        default: begin
          s = "";
          n = $urandom_range(1, 5);
          repeat (n) s = {s, $sformatf("%0d", $urandom_range(0, 9))};
        end
      endcase
      if ($urandom_range(0, 7) == 0) txt.push_back(ChZero);
      for (int i = 0; i < s.len(); i++) txt.push_back(s[i]);
      if ($urandom_range(0, 3) != 0) begin
        txt.push_back(ChPoint);
        nines = ($urandom_range(0, 7) == 0);
        n = $urandom_range(1, 8);
        repeat (n) txt.push_back(nines ? ChNine : ChZero + CharW'($urandom_range(0, 9)));
      end
      if ($urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 3);
        repeat (n) txt.push_back(CharW'($urandom_range(0, 255)));
      end
      if (pick >= 75) begin
        // broken: corrupt one char or cut the text short
        n = $urandom_range(0, txt.size() - 1);
        if ($urandom_range(0, 1) == 0) txt[n] = CharW'($urandom_range(0, 255));
        else while (txt.size() > n + 1) void'(txt.pop_back());
      end
    end
    for (int i = 0; i < txt.size(); i++) push_char(txt[i], i == txt.size() - 1);
  endtask

  // ---------------- driver ----------------

  int         send_gap;
  logic       send_busy;
  text_char_t send_next;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      char_code_i <= '0;
      last_i      <= 1'b0;
      send_gap    = 0;
      send_busy   = 1'b1;
      clear_parser();
    end else begin
      if (in_valid_i && !in_stall_o) begin
        parse_char(char_code_i, last_i);
        chars_sent <= chars_sent + 1;
        if ($urandom_range(0, 79) == 0) send_busy = !send_busy;
        send_gap = send_busy ? $urandom_range(0, 14) : 0;
      end
      if (!in_valid_i || !in_stall_o) begin
        if (send_gap != 0 || text_q.size() == 0) begin
          if (send_gap != 0) send_gap--;
          in_valid_i <= 1'b0;
        end else begin
          send_next    = text_q.pop_front();
          in_valid_i  <= 1'b1;
          char_code_i <= send_next.ch;
          last_i      <= send_next.lst;
        end
      end
    end
  end

  // ---------------- long receiver hold-off ----------------

  int   hold_left;
  logic hold_done;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && chars_sent >= 300) begin
      hold_left <= HoldOffCycles;
      hold_done <= 1'b1;
    end
  end

  // ---------------- monitor ----------------

  int          recv_wait;
  logic        recv_busy;
  q78_result_t want;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
      recv_wait   = 0;
      recv_busy   = 1'b1;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (conv_expected_q.size() == 0) begin
          note_error($sformatf("unexpected result: value %0d status %0d",
                               value_o, status_o));
        end else begin
          want = conv_expected_q.pop_front();
          if (value_o !== want.value || status_o !== want.status)
            note_error($sformatf("result %0d: expected value %0d status %0d, got value %0d status %0d",
                                 results_in, want.value, want.status, value_o, status_o));
        end
        results_in <= results_in + 1;
        if ($urandom_range(0, 15) == 0) recv_busy = !recv_busy;
        recv_wait = recv_busy ? $urandom_range(0, 14) : 0;
      end else if (recv_wait != 0) begin
        recv_wait--;
      end
      out_stall_i <= (recv_wait != 0) || (hold_left != 0);
    end
  end

  // ---------------- sequencing ----------------

  string directed_txt[] = '{
    "127.996",   // largest positive
    "-128",      // largest negative magnitude
    "128",
    "-128.001",  // fraction rounds to zero, still in range
    "-128.002",
    "255",
    "256",       // integer overflow
    "99999",
    "0.999",     // fraction carries into the integer
    "127.999",   // carry pushes past the limit
    "-0",
    "-0.0",
    "1.23456789",
    "12abc",
    "3.5x9",
    "x12",
    "-x",
    "+5",
    "5.",
    "5.x",
    "-",
    "+",
    "999.x",     // format error beats overflow
    "."
  };

  initial begin
    foreach (directed_txt[i]) push_text(directed_txt[i]);
    push_char(8'h00, 1'b1);
    push_char(8'hFF, 1'b1);
    push_char(ChZero + 8'd7, 1'b0);
    push_char(8'hFF, 1'b0);
    push_char(ChZero, 1'b1);
    while (text_q.size() < CharTarget) push_random_number();

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (text_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (conv_expected_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (errors == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

  initial begin
    #(TimeoutCycles * ClkPeriod);
    $display("timeout with %0d results still expected", conv_expected_q.size());
    $display("simulation failed");
    $finish;
  end

endmodule
